[src/sks_pkg.sv]
// sks_pkg: shared widths, types and kernel tables of the selectable kernel smoother.
// Used by sks_front, sks_queue, sks_back and selectable_kernel_smoother_top.
// No dependencies.
package sks_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WIN_LEN     = 7;
    localparam int MODE_W      = 3;
    localparam int CNT_W       = 3;
    localparam int MAX_JOBS    = 4;
    localparam int JIDX_W      = $clog2(MAX_JOBS);
    localparam int JCNT_W      = JIDX_W + 1;
    localparam int OUT_W       = 21;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // arithmetic widths: abs kernel weight sum is at most 47 (< 64)
    localparam int SUM_W   = SAMPLE_BITS + 7;
    localparam int X_W     = SUM_W + 5;
    localparam int QSHIFT  = X_W + 7;
    localparam int RECIP_W = QSHIFT - 3;
    localparam int PROD_W  = X_W + RECIP_W;
    localparam int Q_W     = PROD_W - QSHIFT;
    localparam int QE_W    = (Q_W > OUT_W) ? Q_W : OUT_W;
    localparam int DIV_W   = 6;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_TRI5_9  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRI5_12 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SG5     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRI7    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SG7     = 3'd4;

    // reciprocals of twice the divisor, floor(2^QSHIFT / D) + 1
    localparam logic [63:0] QONE = 64'd1 << QSHIFT;
    localparam logic [RECIP_W-1:0] RCP_12 = RECIP_W'(QONE / 64'd12 + 64'd1);
    localparam logic [RECIP_W-1:0] RCP_16 = RECIP_W'(QONE / 64'd16 + 64'd1);
    localparam logic [RECIP_W-1:0] RCP_18 = RECIP_W'(QONE / 64'd18 + 64'd1);
    localparam logic [RECIP_W-1:0] RCP_24 = RECIP_W'(QONE / 64'd24 + 64'd1);
    localparam logic [RECIP_W-1:0] RCP_32 = RECIP_W'(QONE / 64'd32 + 64'd1);
    localparam logic [RECIP_W-1:0] RCP_42 = RECIP_W'(QONE / 64'd42 + 64'd1);
    localparam logic [RECIP_W-1:0] RCP_70 = RECIP_W'(QONE / 64'd70 + 64'd1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [WIN_LEN-1:0] win_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [3:0] {
        K_TRI5_9  = 4'd0,
        K_TRI5_12 = 4'd1,
        K_SG5     = 4'd2,
        K_TRI7    = 4'd3,
        K_SG7     = 4'd4,
        K_HEAD6   = 4'd5,
        K_HEAD8_0 = 4'd6,
        K_HEAD8_1 = 4'd7,
        K_TAIL8   = 4'd8,
        K_TAIL6   = 4'd9,
        K_ZERO    = 4'd10
    } kernel_t;

    typedef struct packed {
        kernel_t kid;
        logic    last;
        logic    too_short;
    } job_t;

    typedef struct packed {
        win_t                      win;
        job_t [MAX_JOBS-1:0]       jobs;
        logic [JIDX_W-1:0]         last_idx;
    } entry_t;

    function automatic sum_t ext_sample(input sample_t s);
        return {{(SUM_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

    // weighted sum of one kernel over the window, newest sample at index 0
    function automatic sum_t kernel_sum(input kernel_t kid, input win_t win);
        sum_t w [WIN_LEN];
        sum_t acc;
        for (int i = 0; i < WIN_LEN; i++)
        begin
            w[i] = ext_sample(win[i]);
        end
        case (kid)
            K_TRI5_9:  acc = sum_t'(w[0] + 2*w[1] + 3*w[2] + 2*w[3] + w[4]);
            K_TRI5_12: acc = sum_t'(w[0] + 3*w[1] + 4*w[2] + 3*w[3] + w[4]);
            K_SG5:     acc = sum_t'(12*w[1] + 17*w[2] + 12*w[3] - 3*w[0] - 3*w[4]);
            K_TRI7:    acc = sum_t'(w[0] + 2*w[1] + 3*w[2] + 4*w[3] + 3*w[4]
                                    + 2*w[5] + w[6]);
            K_SG7:     acc = sum_t'(3*w[1] + 6*w[2] + 7*w[3] + 6*w[4] + 3*w[5]
                                    - 2*w[0] - 2*w[6]);
            K_HEAD6:   acc = sum_t'(w[1] + 2*w[2] + 3*w[3]);
            K_HEAD8_0: acc = sum_t'(w[0] + 2*w[1] + 3*w[2] + 2*w[3]);
            K_HEAD8_1: acc = sum_t'(w[1] + 2*w[2] + 3*w[3] + 2*w[4]);
            K_TAIL8:   acc = sum_t'(2*w[0] + 3*w[1] + 2*w[2] + w[3]);
            K_TAIL6:   acc = sum_t'(3*w[0] + 2*w[1] + w[2]);
            default:   acc = '0;
        endcase
        return acc;
    endfunction

    function automatic logic [DIV_W-1:0] kernel_div(input kernel_t kid);
        logic [DIV_W-1:0] d;
        case (kid) inside
            K_TRI5_12:                     d = DIV_W'(12);
            K_SG5:                         d = DIV_W'(35);
            K_TRI7:                        d = DIV_W'(16);
            K_SG7:                         d = DIV_W'(21);
            K_HEAD6, K_TAIL6:              d = DIV_W'(6);
            K_HEAD8_0, K_HEAD8_1, K_TAIL8: d = DIV_W'(8);
            default:                       d = DIV_W'(9);
        endcase
        return d;
    endfunction

    function automatic logic [RECIP_W-1:0] kernel_recip(input kernel_t kid);
        logic [RECIP_W-1:0] r;
        case (kid) inside
            K_TRI5_12:                     r = RCP_24;
            K_SG5:                         r = RCP_70;
            K_TRI7:                        r = RCP_32;
            K_SG7:                         r = RCP_42;
            K_HEAD6, K_TAIL6:              r = RCP_12;
            K_HEAD8_0, K_HEAD8_1, K_TAIL8: r = RCP_16;
            default:                       r = RCP_18;
        endcase
        return r;
    endfunction

endpackage

[src/sks_front.sv]
// sks_front: mode register, sample window and record counter; turns each item that
// releases results into a queue entry listing the kernels to run. Depends on sks_pkg.
module sks_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mode_we,
    input  logic [sks_pkg::MODE_W-1:0]  mode_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sks_pkg::sample_t            sample,
    input  logic                        last_sample,
    input  logic                        q_full,
    output logic                        push,
    output sks_pkg::entry_t             push_entry
);

    logic [sks_pkg::MODE_W-1:0]   mode_reg;
    logic [sks_pkg::CNT_W-1:0]    cnt_reg;
    logic [sks_pkg::CNT_W-1:0]    cnt_next;
    sks_pkg::win_t                win_reg;
    sks_pkg::win_t                win_next;
    logic                         accept;
    logic                         seven;
    sks_pkg::kernel_t             inner_kid;
    sks_pkg::job_t [sks_pkg::MAX_JOBS-1:0] jobs;
    logic [sks_pkg::JCNT_W-1:0]   njobs;
    logic                         short_rec;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign win_next = {win_reg[sks_pkg::WIN_LEN-2:0], sample};

    always_comb
    begin
        unique case (mode_reg)
            sks_pkg::MODE_TRI5_12: inner_kid = sks_pkg::K_TRI5_12;
            sks_pkg::MODE_SG5:     inner_kid = sks_pkg::K_SG5;
            sks_pkg::MODE_TRI7:    inner_kid = sks_pkg::K_TRI7;
            sks_pkg::MODE_SG7:     inner_kid = sks_pkg::K_SG7;
            default:               inner_kid = sks_pkg::K_TRI5_9;
        endcase
        seven = (mode_reg == sks_pkg::MODE_TRI7) || (mode_reg == sks_pkg::MODE_SG7);
    end

    // result schedule for the incoming sample
    always_comb
    begin
        for (int i = 0; i < sks_pkg::MAX_JOBS; i++)
        begin
            jobs[i] = '{kid: sks_pkg::K_ZERO, last: 1'b0, too_short: 1'b0};
        end
        njobs     = '0;
        short_rec = last_sample && (seven ? (cnt_reg < 3'd4) : (cnt_reg < 3'd3));
        if (short_rec)
        begin
            jobs[0] = '{kid: sks_pkg::K_ZERO, last: 1'b1, too_short: 1'b1};
            njobs   = sks_pkg::JCNT_W'(1);
        end
        else
        begin
            if (!seven)
            begin
                if (cnt_reg == 3'd3)
                begin
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_HEAD6, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_HEAD8_0, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                end
                else if (cnt_reg >= 3'd4)
                begin
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{inner_kid, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                end
            end
            else
            begin
                if (cnt_reg == 3'd3)
                begin
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_HEAD6, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                end
                else if (cnt_reg == 3'd4)
                begin
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_HEAD8_1, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_TRI5_9, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                end
                else if (cnt_reg >= 3'd6)
                begin
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{inner_kid, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                end
                // the 1-2-3-2-1 result next to the tail edge
                if (last_sample && cnt_reg >= 3'd5)
                begin
                    jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_TRI5_9, 1'b0, 1'b0};
                    njobs = njobs + 1'b1;
                end
            end
            if (last_sample)
            begin
                jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_TAIL8, 1'b0, 1'b0};
                njobs = njobs + 1'b1;
                jobs[njobs[sks_pkg::JIDX_W-1:0]] = '{sks_pkg::K_TAIL6, 1'b1, 1'b0};
                njobs = njobs + 1'b1;
            end
        end
    end

    assign push                = accept && (njobs != '0);
    assign push_entry.win      = win_next;
    assign push_entry.jobs     = jobs;
    assign push_entry.last_idx = sks_pkg::JIDX_W'(njobs - 1'b1);

    always_comb
    begin
        if (last_sample)
            cnt_next = '0;
        else if (cnt_reg != 3'd7)
            cnt_next = cnt_reg + 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sks_pkg::MODE_TRI5_9;
            cnt_reg  <= '0;
            win_reg  <= '0;
        end
        else
        begin
            if (mode_we)
                mode_reg <= mode_wdata;
            if (accept)
            begin
                cnt_reg <= cnt_next;
                win_reg <= win_next;
            end
        end
    end

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_sample |=> cnt_reg == '0)
        else $error("record counter not cleared after last item");

    a_last_job: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_entry.jobs[push_entry.last_idx].last == last_sample))
        else $error("final job of entry disagrees with last_sample");

endmodule

[src/sks_queue.sv]
// sks_queue: short first-in first-out queue of job entries between front and back.
// Depends on sks_pkg.
module sks_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sks_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output sks_pkg::entry_t head
);

    sks_pkg::entry_t               mem_reg [sks_pkg::QDEPTH];
    logic [sks_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sks_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sks_pkg::QCNT_W-1:0]    count_reg;
    logic [sks_pkg::QCNT_W-1:0]    count_next;

    assign full  = (count_reg == sks_pkg::QCNT_W'(sks_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sks_pkg::QCNT_W'(sks_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

[src/sks_back.sv]
// sks_back: issues the queue head's jobs one per cycle when not stalled, runs them through
// weighted sum, rounding numerator, reciprocal multiply and saturation. Depends on sks_pkg.
module sks_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sks_pkg::entry_t               head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [sks_pkg::OUT_W-1:0] smoothed,
    output logic                          last_result,
    output logic                          too_short
);

    logic                           en;
    logic                           issue;
    sks_pkg::job_t                  job;
    logic [sks_pkg::JIDX_W-1:0]     jidx_reg;

    // stage 1: weighted sum
    logic                           s1_valid_reg;
    sks_pkg::sum_t                  s1_sum_reg;
    sks_pkg::kernel_t               s1_kid_reg;
    logic                           s1_last_reg;
    logic                           s1_short_reg;

    // stage 2: 2*|16*sum| + divisor
    logic                           s2_valid_reg;
    logic [sks_pkg::X_W-1:0]        s2_x_reg;
    logic [sks_pkg::X_W-1:0]        s2_x_next;
    logic                           s2_neg_reg;
    sks_pkg::kernel_t               s2_kid_reg;
    logic                           s2_last_reg;
    logic                           s2_short_reg;
    logic [sks_pkg::SUM_W-1:0]      mag;

    // stage 3: reciprocal product
    logic                           s3_valid_reg;
    logic [sks_pkg::PROD_W-1:0]     s3_prod_reg;
    logic                           s3_neg_reg;
    logic                           s3_last_reg;
    logic                           s3_short_reg;

    // output register
    logic                           out_valid_reg;
    logic signed [sks_pkg::OUT_W-1:0] smoothed_reg;
    logic signed [sks_pkg::OUT_W-1:0] smoothed_next;
    logic                           last_reg;
    logic                           short_reg;
    logic [sks_pkg::QE_W-1:0]       qe;

    localparam logic [sks_pkg::QE_W-1:0] POS_LIM =
        sks_pkg::QE_W'((64'd1 << (sks_pkg::OUT_W - 1)) - 64'd1);
    localparam logic [sks_pkg::QE_W-1:0] NEG_LIM =
        sks_pkg::QE_W'(64'd1 << (sks_pkg::OUT_W - 1));

    // whole pipeline moves when the output register is free or being taken
    assign en    = !out_valid_reg || !out_stall;
    assign issue = en && !q_empty;
    assign job   = head.jobs[jidx_reg];
    assign pop   = issue && (jidx_reg == head.last_idx);

    assign mag       = s1_sum_reg[sks_pkg::SUM_W-1] ? sks_pkg::SUM_W'(-s1_sum_reg)
                                                    : sks_pkg::SUM_W'(s1_sum_reg);
    assign s2_x_next = {mag, 5'b0} + sks_pkg::X_W'(sks_pkg::kernel_div(s1_kid_reg));

    assign qe = sks_pkg::QE_W'(s3_prod_reg[sks_pkg::PROD_W-1:sks_pkg::QSHIFT]);

    always_comb
    begin
        if (!s3_neg_reg)
            smoothed_next = (qe > POS_LIM) ? sks_pkg::OUT_W'(POS_LIM)
                                           : qe[sks_pkg::OUT_W-1:0];
        else
            smoothed_next = (qe > NEG_LIM) ? sks_pkg::OUT_W'(NEG_LIM)
                                           : -qe[sks_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jidx_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (pop)
                jidx_reg <= '0;
            else if (issue)
                jidx_reg <= jidx_reg + 1'b1;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sum_reg   <= sks_pkg::kernel_sum(job.kid, head.win);
            s1_kid_reg   <= job.kid;
            s1_last_reg  <= job.last;
            s1_short_reg <= job.too_short;

            s2_x_reg     <= s2_x_next;
            s2_neg_reg   <= s1_sum_reg[sks_pkg::SUM_W-1];
            s2_kid_reg   <= s1_kid_reg;
            s2_last_reg  <= s1_last_reg;
            s2_short_reg <= s1_short_reg;

            s3_prod_reg  <= sks_pkg::PROD_W'(s2_x_reg)
                            * sks_pkg::PROD_W'(sks_pkg::kernel_recip(s2_kid_reg));
            s3_neg_reg   <= s2_neg_reg;
            s3_last_reg  <= s2_last_reg;
            s3_short_reg <= s2_short_reg;

            smoothed_reg <= smoothed_next;
            last_reg     <= s3_last_reg;
            short_reg    <= s3_short_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign smoothed    = smoothed_reg;
    assign last_result = last_reg;
    assign too_short   = short_reg;

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_short |-> last_result && (smoothed == '0))
        else $error("short record result not a zero final value");

    a_jidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> jidx_reg <= head.last_idx)
        else $error("job index past end of entry");

endmodule

[src/selectable_kernel_smoother_top.sv]
// selectable_kernel_smoother_top: top level of the selectable kernel smoother.
// Depends on sks_pkg, sks_front, sks_queue and sks_back.
//
// Usage:
// - kernel_mode_we / kernel_mode_wdata write the kernel mode (0..4, other codes
//   act as mode 0); write it only while the block is idle.
// - input channel in_valid / in_stall carries sample and last_sample; an item is
//   taken at a clock edge with in_valid high and in_stall low.
// - output channel out_valid / out_stall carries smoothed (four fractional bits),
//   last_result and too_short.
// - throughput: one item per cycle while in_stall is low. An item gives zero to
//   four results; the back pipeline issues one result per cycle while out_stall
//   does not hold it, so the extra edge results at a record end are absorbed by
//   the four-entry job queue and in_stall rises when it fills.
// - the first result of an item passes the queue write, weighted sum, rounding
//   numerator, reciprocal multiply and then the output register.
// - reset clears the mode to 0, the sample window, the record count and the queue.
// - while out_stall is high with out_valid high, the output holds and the whole
//   back pipeline freezes; items keep being taken until the queue is full.
module selectable_kernel_smoother_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            kernel_mode_we,
    input  logic [sks_pkg::MODE_W-1:0]      kernel_mode_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [sks_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            last_sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [sks_pkg::OUT_W-1:0] smoothed,
    output logic                            last_result,
    output logic                            too_short
);

    logic            push;
    sks_pkg::entry_t push_entry;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    sks_pkg::entry_t head;

    sks_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_we     (kernel_mode_we),
        .mode_wdata  (kernel_mode_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    sks_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    sks_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .smoothed    (smoothed),
        .last_result (last_result),
        .too_short   (too_short)
    );

endmodule

[verif/tb_selectable_kernel_smoother_top.sv]
`timescale 1ns / 1ps
// tb_selectable_kernel_smoother_top: self-checking bench for the selectable kernel smoother,
// a clocked driver and monitor around a bit-exact prediction of every smoothed result.
// Depends on sks_pkg and selectable_kernel_smoother_top.
module tb_selectable_kernel_smoother_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 14;
    localparam int OUT_HI      = 1048575;
    localparam int OUT_LO      = -1048576;

    // codes outside the kernel table, the block treats them as mode 0
    localparam logic [sks_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [sks_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [sks_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef enum {
        W_TRI5_9, W_TRI5_12, W_SG5, W_TRI7, W_SG7,
        W_HEAD6, W_TAIL6, W_HEAD8, W_TAIL8
    } weights_t;

    typedef struct {
        logic signed [sks_pkg::SAMPLE_BITS-1:0] value;
        logic                                   last;
    } sample_item_t;

    typedef struct {
        logic signed [sks_pkg::OUT_W-1:0] value;
        logic                             last;
        logic                             short_rec;
    } smoothed_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic kernel_mode_we = 1'b0;
    logic [sks_pkg::MODE_W-1:0] kernel_mode_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [sks_pkg::SAMPLE_BITS-1:0] sample = '0;
    logic last_sample = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [sks_pkg::OUT_W-1:0] smoothed;
    logic last_result;
    logic too_short;

    sample_item_t   sample_feed[$];
    smoothed_item_t pending_smoothed[$];

    // predictor state
    logic signed [sks_pkg::SAMPLE_BITS-1:0] win [sks_pkg::WIN_LEN];
    logic [sks_pkg::CNT_W-1:0]              rec_count;
    logic [sks_pkg::MODE_W-1:0]             mode_reg;

    int  mismatches = 0;
    int  cycles = 0;
    bit  steady = 1'b0;
    bit  long_hold = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    selectable_kernel_smoother_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .kernel_mode_we    (kernel_mode_we),
        .kernel_mode_wdata (kernel_mode_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .last_sample       (last_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .smoothed          (smoothed),
        .last_result       (last_result),
        .too_short         (too_short)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // weighted sum over win[first..], times 16, divided with ties away from zero and clamped
    function automatic logic signed [sks_pkg::OUT_W-1:0] weigh(input weights_t w,
                                                               input int first);
        int     c [7];
        longint d;
        longint acc;
        longint q;
        int     p;
        acc = 0;
        case (w)
            W_TRI5_9:  begin c = '{1, 2, 3, 2, 1, 0, 0};     d = 9;  end
            W_TRI5_12: begin c = '{1, 3, 4, 3, 1, 0, 0};     d = 12; end
            W_SG5:     begin c = '{-3, 12, 17, 12, -3, 0, 0}; d = 35; end
            W_TRI7:    begin c = '{1, 2, 3, 4, 3, 2, 1};     d = 16; end
            W_SG7:     begin c = '{-2, 3, 6, 7, 6, 3, -2};   d = 21; end
            W_HEAD6:   begin c = '{1, 2, 3, 0, 0, 0, 0};     d = 6;  end
            W_TAIL6:   begin c = '{3, 2, 1, 0, 0, 0, 0};     d = 6;  end
            W_HEAD8:   begin c = '{1, 2, 3, 2, 0, 0, 0};     d = 8;  end
            default:   begin c = '{2, 3, 2, 1, 0, 0, 0};     d = 8;  end
        endcase
        for (int j = 0; j < 7; j++)
        begin
            p = first + j;
            if (p >= 0 && p < sks_pkg::WIN_LEN)
                acc += longint'(c[j]) * longint'(win[p]);
        end
        acc = acc * 16;
        if (acc >= 0)
            q = (2 * acc + d) / (2 * d);
        else
            q = -((2 * (-acc) + d) / (2 * d));
        if (q > OUT_HI)
            q = OUT_HI;
        if (q < OUT_LO)
            q = OUT_LO;
        return sks_pkg::OUT_W'(q);
    endfunction

    function automatic weights_t mode_weights(input logic [sks_pkg::MODE_W-1:0] m);
        case (m)
            sks_pkg::MODE_TRI5_12: return W_TRI5_12;
            sks_pkg::MODE_SG5:     return W_SG5;
            sks_pkg::MODE_TRI7:    return W_TRI7;
            sks_pkg::MODE_SG7:     return W_SG7;
            default:               return W_TRI5_9;
        endcase
    endfunction

    task automatic expect_smoothed(input logic signed [sks_pkg::OUT_W-1:0] v, input logic l,
                                   input logic s);
        smoothed_item_t r;
        r.value = v;
        r.last = l;
        r.short_rec = s;
        pending_smoothed.push_back(r);
    endtask

    // advances the window by one sample and queues the results it releases
    task automatic smooth_sample(input logic signed [sks_pkg::SAMPLE_BITS-1:0] s,
                                 input logic l);
        int         k;
        bit         seven;
        int         min_len;
        weights_t   main_w;
        seven = (mode_reg == sks_pkg::MODE_TRI7) || (mode_reg == sks_pkg::MODE_SG7);
        min_len = seven ? 5 : 4;
        main_w = mode_weights(mode_reg);
        for (int i = sks_pkg::WIN_LEN - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = s;
        k = rec_count;
        if (rec_count < 7)
            rec_count++;
        if (l && k + 1 < min_len)
        begin
            rec_count = '0;
            expect_smoothed('0, 1'b1, 1'b1);
            return;
        end
        if (!seven)
        begin
            if (k == 3)
            begin
                expect_smoothed(weigh(W_HEAD6, 1), 1'b0, 1'b0);
                expect_smoothed(weigh(W_HEAD8, 0), 1'b0, 1'b0);
            end
            else if (k >= 4)
                expect_smoothed(weigh(main_w, 0), 1'b0, 1'b0);
        end
        else
        begin
            if (k == 3)
                expect_smoothed(weigh(W_HEAD6, 1), 1'b0, 1'b0);
            else if (k == 4)
            begin
                expect_smoothed(weigh(W_HEAD8, 1), 1'b0, 1'b0);
                expect_smoothed(weigh(W_TRI5_9, 0), 1'b0, 1'b0);
            end
            else if (k >= 6)
                expect_smoothed(weigh(main_w, 0), 1'b0, 1'b0);
            if (l && k >= 5)
                expect_smoothed(weigh(W_TRI5_9, 0), 1'b0, 1'b0);
        end
        if (l)
        begin
            expect_smoothed(weigh(W_TAIL8, 0), 1'b0, 1'b0);
            expect_smoothed(weigh(W_TAIL6, 0), 1'b1, 1'b0);
            rec_count = '0;
        end
    endtask

    // driver: offers items from the feed, holds a stalled item unchanged
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        sample_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            last_sample <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                smooth_sample(sample, last_sample);
            if (!in_valid || !in_stall)
            begin
                if (sample_feed.size() != 0
                    && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = sample_feed.pop_front();
                    in_valid <= 1'b1;
                    sample <= nxt.value;
                    last_sample <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure plus one long hold, checks every result
    always @(posedge clk or negedge rst_n)
    begin : check_results
        smoothed_item_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_smoothed.size() == 0)
                begin
                    $error("unexpected result: smoothed %0d last %0b short %0b",
                           smoothed, last_result, too_short);
                    mismatches++;
                end
                else
                begin
                    exp_r = pending_smoothed.pop_front();
                    if (smoothed !== exp_r.value)
                    begin
                        $error("smoothed: expected %0d, got %0d", exp_r.value, smoothed);
                        mismatches++;
                    end
                    if (last_result !== exp_r.last)
                    begin
                        $error("last_result: expected %0b, got %0b", exp_r.last, last_result);
                        mismatches++;
                    end
                    if (too_short !== exp_r.short_rec)
                    begin
                        $error("too_short: expected %0b, got %0b", exp_r.short_rec, too_short);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (long_hold && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
                out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_selectable_kernel_smoother_top: errors");
            $finish;
        end
    end

    task automatic push_sample(input logic signed [sks_pkg::SAMPLE_BITS-1:0] v,
                               input logic l);
        sample_item_t it;
        it.value = v;
        it.last = l;
        sample_feed.push_back(it);
    endtask

    function automatic logic signed [sks_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return sks_pkg::SAMPLE_BITS'($urandom_range(0, 15) - 8);
            default: return sks_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // whole records, mostly long enough to reach the interior kernel
    task automatic load_records(input int n_items);
        int loaded;
        int len;
        loaded = 0;
        @(negedge clk);
        while (loaded < n_items)
        begin
            if ($urandom_range(0, 9) < 2)
                len = $urandom_range(1, 5);
            else
                len = $urandom_range(5, 14);
            for (int i = 0; i < len; i++)
                push_sample(pick_sample(), i == len - 1);
            loaded += len;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (sample_feed.size() != 0 || in_valid || pending_smoothed.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_mode(input logic [sks_pkg::MODE_W-1:0] m);
        @(posedge clk);
        kernel_mode_we <= 1'b1;
        kernel_mode_wdata <= m;
        @(posedge clk);
        kernel_mode_we <= 1'b0;
        mode_reg = m;
    endtask

    initial
    begin : run_phases
        logic [sks_pkg::MODE_W-1:0] modes [10];
        modes = '{sks_pkg::MODE_TRI5_12, sks_pkg::MODE_SG7, sks_pkg::MODE_SG5,
                  sks_pkg::MODE_TRI7, MODE_SPARE_7, sks_pkg::MODE_TRI5_9, MODE_SPARE_5,
                  sks_pkg::MODE_SG7, MODE_SPARE_6, sks_pkg::MODE_TRI5_9};
        for (int i = 0; i < sks_pkg::WIN_LEN; i++)
            win[i] = '0;
        rec_count = '0;
        mode_reg = sks_pkg::MODE_TRI5_9;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // five-point: one-sample record, then the shortest full record at the extremes
        write_mode(sks_pkg::MODE_TRI5_9);
        @(negedge clk);
        push_sample(16'sh0123, 1'b1);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(16'shffff, 1'b1);
        drain();

        // seven-point: last item of the shortest full record gives four results,
        // four samples is too short
        write_mode(sks_pkg::MODE_TRI7);
        @(negedge clk);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b1);
        push_sample(16'sh0010, 1'b0);
        push_sample(16'shfff0, 1'b0);
        push_sample(16'sh0020, 1'b0);
        push_sample(16'sh5555, 1'b1);
        drain();

        // mode switch part way through a record
        write_mode(sks_pkg::MODE_SG5);
        @(negedge clk);
        for (int i = 0; i < 5; i++)
            push_sample(sks_pkg::SAMPLE_BITS'(i * 9000 - 18000), 1'b0);
        drain();
        write_mode(sks_pkg::MODE_SG7);
        @(negedge clk);
        push_sample(16'sh2aaa, 1'b0);
        push_sample(16'shd555, 1'b0);
        push_sample(16'sh4000, 1'b1);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            write_mode(modes[ph]);
            steady = (ph == 3) || (ph == 5);
            load_records(PHASE_ITEMS);
            if (ph == 5)
                long_hold = 1'b1;
            drain();
        end
        steady = 1'b0;

        if (mismatches == 0)
            $display("tb_selectable_kernel_smoother_top: clean");
        else
            $display("tb_selectable_kernel_smoother_top: errors");
        $finish;
    end

endmodule
